[design/modexp_pkg.sv]
// Shared constants for the modular exponentiation block.
package modexp_pkg;

	// Configuration port geometry
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	// Register indexes, selected by paddr[2]
	localparam logic REG_EXPONENT = 1'b0;
	localparam logic REG_MODULUS  = 1'b1;

	// Register reset values before truncation to the value width
	localparam logic [CFG_DATA_W-1:0] EXPONENT_RESET = 32'd1;
	localparam logic [CFG_DATA_W-1:0] MODULUS_RESET  = 32'd65535;

endpackage

[design/modexp_regs.sv]
// Key registers (exponent, modulus) behind the APB-style configuration port.
module modexp_regs #(
	parameter int W = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [modexp_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [modexp_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [modexp_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                                 pready,
	output logic [W-1:0]                         exponent,
	output logic [W-1:0]                         modulus
);

	logic [W-1:0] exponent_q;
	logic [W-1:0] modulus_q;
	logic         wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= modexp_pkg::EXPONENT_RESET[W-1:0];
			modulus_q  <= modexp_pkg::MODULUS_RESET[W-1:0];
		end else if (wr_en) begin
			unique case (paddr[2])
				modexp_pkg::REG_EXPONENT: exponent_q <= pwdata[W-1:0];
				modexp_pkg::REG_MODULUS:  modulus_q  <= pwdata[W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			modexp_pkg::REG_EXPONENT: prdata = modexp_pkg::CFG_DATA_W'(exponent_q);
			modexp_pkg::REG_MODULUS:  prdata = modexp_pkg::CFG_DATA_W'(modulus_q);
			default:                  prdata = '0;
		endcase
	end

	assign exponent = exponent_q;
	assign modulus  = modulus_q;

endmodule

[design/modexp_mulmod.sv]
// Bit-serial modular multiplier: r = a * b mod m, one bit of b per cycle, MSB first.
module modexp_mulmod #(
	parameter int W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] m,
	output logic         busy,
	output logic         done,
	output logic [W-1:0] r
);

	localparam int CW = $clog2(W);

	logic [W-1:0]  r_q;
	logic [W-1:0]  b_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W+1:0]  sum;
	logic [W+1:0]  m1;
	logic [W+1:0]  m2;
	logic [W+1:0]  d1;
	logic [W+1:0]  d2;
	logic [W-1:0]  r_next;

	// a must be below m, so 2r + a stays below 3m; at most two subtractions of m
	always_comb begin
		sum = {1'b0, r_q, 1'b0} + (b_q[W-1] ? {2'b00, a} : '0);
		m1  = {2'b00, m};
		m2  = {1'b0, m, 1'b0};
		d1  = sum - m1;
		d2  = sum - m2;
		priority if (sum >= m2) begin
			r_next = d2[W-1:0];
		end else if (sum >= m1) begin
			r_next = d1[W-1:0];
		end else begin
			r_next = sum[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q    <= '0;
			b_q    <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				r_q    <= '0;
				b_q    <= b;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				r_q   <= r_next;
				b_q   <= {b_q[W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign r    = r_q;

endmodule

[design/modular_exponentiation.sv]
// Modular exponentiation top level: square-and-multiply sequencer over a shared multiplier.
//
// Usage:
//   Write the exponent (byte address 0) and the modulus (byte address 4) on the APB
//   port while the block is idle. Each word accepted on s_tdata is reduced mod modulus
//   and raised to the exponent; the result appears on m_tdata.
//   An item takes one reduction plus VALUE_WIDTH squarings plus one multiplication per
//   set exponent bit. A modulus below 2 gives 0 without any multiplication.
//   The multiplier unit sets the rate: one item is in work at a time and s_tready
//   stays low until it is done.
//   The result is held in an output register; the next word is accepted while it
//   waits, and a stalled receiver blocks the block only when a second result is ready.
//   Reset clears the key registers to exponent 1, modulus 65535 (truncated to width)
//   and drops any item in work or result waiting.
module modular_exponentiation #(
	parameter int VALUE_WIDTH = 16,
	localparam int DATA_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [modexp_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [modexp_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [modexp_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                                 pready,
	// input words
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [DATA_W-1:0]                    s_tdata,  // message_value, zero pad
	// result words
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [DATA_W-1:0]                    m_tdata   // power_result, zero pad
);

	localparam int BW = $clog2(VALUE_WIDTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SQUARE,
		ST_MULT,
		ST_FINISH
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] base_q;
	logic [VALUE_WIDTH-1:0] acc_q;
	logic [VALUE_WIDTH-1:0] exp_q;
	logic [BW-1:0]          bit_q;
	logic                   start_q;
	logic                   m_tvalid_q;
	logic [VALUE_WIDTH-1:0] out_q;

	logic [VALUE_WIDTH-1:0] exponent;
	logic [VALUE_WIDTH-1:0] modulus;
	logic [VALUE_WIDTH-1:0] mm_a;
	logic [VALUE_WIDTH-1:0] mm_b;
	logic [VALUE_WIDTH-1:0] mm_r;
	logic                   mm_busy;
	logic                   mm_done;
	logic                   last_bit;

	modexp_regs #(
		.W (VALUE_WIDTH)
	) u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.exponent (exponent),
		.modulus  (modulus)
	);

	// Operand select by step: reduce base as 1 * msg, square acc, multiply acc by base
	always_comb begin
		unique case (state_q)
			ST_REDUCE: begin
				mm_a = VALUE_WIDTH'(1);
				mm_b = base_q;
			end
			ST_MULT: begin
				mm_a = base_q;
				mm_b = acc_q;
			end
			default: begin
				mm_a = acc_q;
				mm_b = acc_q;
			end
		endcase
	end

	modexp_mulmod #(
		.W (VALUE_WIDTH)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.a      (mm_a),
		.b      (mm_b),
		.m      (modulus),
		.busy   (mm_busy),
		.done   (mm_done),
		.r      (mm_r)
	);

	assign last_bit = (bit_q == BW'(VALUE_WIDTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			base_q     <= '0;
			acc_q      <= '0;
			exp_q      <= '0;
			bit_q      <= '0;
			start_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			out_q      <= '0;
		end else begin
			start_q <= 1'b0;
			if (m_tvalid_q && m_tready && state_q != ST_FINISH) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						base_q <= s_tdata[VALUE_WIDTH-1:0];
						if (modulus < VALUE_WIDTH'(2)) begin
							acc_q   <= '0;
							state_q <= ST_FINISH;
						end else begin
							start_q <= 1'b1;
							state_q <= ST_REDUCE;
						end
					end
				end
				ST_REDUCE: begin
					if (mm_done) begin
						base_q  <= mm_r;
						acc_q   <= VALUE_WIDTH'(1);
						exp_q   <= exponent;
						bit_q   <= '0;
						start_q <= 1'b1;
						state_q <= ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					if (mm_done) begin
						acc_q <= mm_r;
						if (exp_q[VALUE_WIDTH-1]) begin
							start_q <= 1'b1;
							state_q <= ST_MULT;
						end else if (last_bit) begin
							state_q <= ST_FINISH;
						end else begin
							exp_q   <= {exp_q[VALUE_WIDTH-2:0], 1'b0};
							bit_q   <= bit_q + 1'b1;
							start_q <= 1'b1;
						end
					end
				end
				ST_MULT: begin
					if (mm_done) begin
						acc_q <= mm_r;
						if (last_bit) begin
							state_q <= ST_FINISH;
						end else begin
							exp_q   <= {exp_q[VALUE_WIDTH-2:0], 1'b0};
							bit_q   <= bit_q + 1'b1;
							start_q <= 1'b1;
							state_q <= ST_SQUARE;
						end
					end
				end
				ST_FINISH: begin
					// hand over once the output register is free or being drained
					if (!m_tvalid_q || m_tready) begin
						out_q      <= acc_q;
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = DATA_W'(out_q);

`ifndef SYNTHESIS
	a_start_idle_unit: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> !mm_busy)
		else $error("multiplier started while busy");

	a_done_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		mm_done |-> (state_q == ST_REDUCE || state_q == ST_SQUARE || state_q == ST_MULT))
		else $error("multiplier result outside a multiply step");

	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQUARE || state_q == ST_MULT) && modulus >= VALUE_WIDTH'(2)
		|-> acc_q < modulus)
		else $error("accumulator not reduced");

	a_base_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		start_q && state_q == ST_MULT |-> base_q < modulus)
		else $error("base not reduced before multiply");

	a_result_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && modulus >= VALUE_WIDTH'(2) |-> out_q < modulus)
		else $error("result not below modulus");
`endif

endmodule

[dv/testbench.sv]
// Self-checking testbench for the modular exponentiation block: APB keys, stream words.
`timescale 1ns / 100ps

module testbench;

	localparam int VALUE_W          = 16;
	localparam int STRAY_W          = modexp_pkg::CFG_DATA_W - VALUE_W;
	localparam int MAX_ITEM_CYCLES  = 600;
	localparam int LONG_HOLD_CYCLES = 4000;
	localparam int CYCLE_LIMIT      = 3_000_000;
	localparam int RANDOM_PHASES    = 12;
	localparam int WORDS_PER_PHASE  = 90;

	logic                              clk;
	logic                              arst_n;
	logic                              psel;
	logic                              penable;
	logic                              pwrite;
	logic [modexp_pkg::CFG_ADDR_W-1:0] paddr;
	logic [modexp_pkg::CFG_DATA_W-1:0] pwdata;
	logic [modexp_pkg::CFG_DATA_W-1:0] prdata;
	logic                              pready;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [VALUE_W-1:0]                s_tdata;   // message_value
	logic                              m_tvalid;
	logic                              m_tready;
	logic [VALUE_W-1:0]                m_tdata;   // power_result

	logic [VALUE_W-1:0] key_exponent;
	logic [VALUE_W-1:0] key_modulus;
	logic [VALUE_W-1:0] expected_powers[$];
	bit                 no_idle;
	bit                 long_hold_request;
	int                 error_count;
	int                 words_sent;
	int                 results_checked;
	int                 key_settings;
	int                 cycle_count;

	modular_exponentiation uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Square-and-multiply at double width, so no product overflows.
	function automatic logic [VALUE_W-1:0] modpow(input logic [VALUE_W-1:0] base_in,
		input logic [VALUE_W-1:0] exp_in, input logic [VALUE_W-1:0] mod_in);
		logic [2*VALUE_W-1:0] acc;
		logic [2*VALUE_W-1:0] base_r;
		if (mod_in < 2) begin
			return '0;
		end
		base_r = base_in % mod_in;
		acc = 1;
		for (int b = VALUE_W - 1; b >= 0; b--) begin
			acc = (acc * acc) % mod_in;
			if (exp_in[b]) begin
				acc = (acc * base_r) % mod_in;
			end
		end
		return acc[VALUE_W-1:0];
	endfunction

	task automatic send_word(input logic [VALUE_W-1:0] value);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		expected_powers.push_back(modpow(value, key_exponent, key_modulus));
		words_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_powers.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_key(input logic reg_index, input logic [VALUE_W-1:0] value);
		logic [STRAY_W-1:0] stray;
		stray = STRAY_W'($urandom);
		// setup phase, with junk above the value width
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_index, 2'b00};
		pwdata  <= {stray, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_index == modexp_pkg::REG_EXPONENT) begin
			key_exponent = value;
		end else begin
			key_modulus = value;
		end
		@(posedge clk);
	endtask

	task automatic set_keys(input logic [VALUE_W-1:0] exp_val, input logic [VALUE_W-1:0] mod_val);
		drain_results();
		write_key(modexp_pkg::REG_EXPONENT, exp_val);
		write_key(modexp_pkg::REG_MODULUS, mod_val);
		key_settings++;
	endtask

	task automatic test_reset_keys();
		send_word(16'd0);
		send_word(16'd1);
		send_word(16'd65534);
		send_word(16'd65535);
	endtask

	task automatic test_key_corners();
		// zero exponent gives 1, even for a zero message
		set_keys(16'd0, 16'd65535);
		send_word(16'd0);
		send_word(16'd65535);
		set_keys(16'd65535, 16'd65521);
		send_word(16'd2);
		send_word(16'd65535);
		set_keys(16'd3, 16'd2);
		send_word(16'd0);
		send_word(16'd1);
		send_word(16'd65535);
		set_keys(16'd2, 16'd3);
		send_word(16'd65534);
		// modulus below two gives zero
		set_keys(16'd7, 16'd0);
		send_word(16'd5);
		set_keys(16'd0, 16'd1);
		send_word(16'd7);
		set_keys(16'd0, 16'd0);
		send_word(16'd0);
		set_keys(16'd5, 16'd1000);
		send_word(16'd999);
		send_word(16'd1000);
	endtask

	task automatic test_output_backpressure();
		set_keys(16'h8001, 16'd40961);
		no_idle = 1'b1;
		long_hold_request = 1'b1;
		for (int i = 0; i < 8; i++) begin
			send_word(16'($urandom));
		end
		no_idle = 1'b0;
		drain_results();
	endtask

	task automatic test_sender_pause();
		set_keys(16'd17, 16'd3233);
		for (int i = 0; i < 5; i++) begin
			send_word(16'($urandom));
		end
		drain_results();
		for (int i = 0; i < 5; i++) begin
			send_word(16'($urandom_range(0, 3232)));
		end
	endtask

	task automatic test_random_keys();
		logic [VALUE_W-1:0] exp_val;
		logic [VALUE_W-1:0] mod_val;
		logic [VALUE_W-1:0] msg;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			exp_val = VALUE_W'($urandom);
			mod_val = VALUE_W'($urandom_range(2, 65535));
			case (phase)
				0: begin
					exp_val = 16'hFFFF;
					mod_val = 16'hFFFF;
				end
				1: exp_val = '0;
				2: mod_val = 16'd2;
				3: mod_val = VALUE_W'($urandom_range(0, 1));
				4: begin
					exp_val = 16'd1;
					mod_val = 16'd3;
				end
				default: ;
			endcase
			set_keys(exp_val, mod_val);
			no_idle = (phase % 4 == 3);
			for (int i = 0; i < WORDS_PER_PHASE; i++) begin
				case ($urandom_range(0, 9))
					0: msg = '0;
					1: msg = '1;
					2: msg = VALUE_W'(key_modulus - 1);
					3: msg = key_modulus;
					4: msg = VALUE_W'(key_modulus + 1);
					default: msg = VALUE_W'($urandom);
				endcase
				send_word(msg);
			end
			no_idle = 1'b0;
		end
	endtask

	// Result side: random stalls per word unless no_idle is set, one long hold on request.
	initial begin : result_check
		int stall;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			if (long_hold_request) begin
				long_hold_request = 1'b0;
				m_tready <= 1'b0;
				for (int held = 0; held < LONG_HOLD_CYCLES; held++) @(posedge clk);
			end
			stall = no_idle ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (expected_powers.size() == 0) begin
				$error("result word with no expectation pending: power_result %0d", m_tdata);
				error_count++;
			end else begin
				if (m_tdata !== expected_powers[0]) begin
					$error("power_result mismatch: expected %0d, actual %0d",
						expected_powers[0], m_tdata);
					error_count++;
				end
				void'(expected_powers.pop_front());
				results_checked++;
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			expected_powers.size());
		$display("FAILURE");
		$finish;
	end

	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		s_tvalid          = 1'b0;
		s_tdata           = '0;
		no_idle           = 1'b0;
		long_hold_request = 1'b0;
		error_count       = 0;
		words_sent        = 0;
		results_checked   = 0;
		key_settings      = 0;
		key_exponent      = modexp_pkg::EXPONENT_RESET[VALUE_W-1:0];
		key_modulus       = modexp_pkg::MODULUS_RESET[VALUE_W-1:0];
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_keys();
		test_key_corners();
		test_output_backpressure();
		test_sender_pause();
		test_random_keys();

		drain_results();
		repeat (MAX_ITEM_CYCLES) @(posedge clk);
		$display("%0d words sent, %0d results checked over %0d key settings",
			words_sent, results_checked, key_settings);
		$display("covered zero and full exponents, moduli 0..65535 edges, reduction, long stall");
		if (error_count == 0 && expected_powers.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
